[src/kdlpr_pkg.sv]
package kdlpr_pkg;

  // fixed field widths
  localparam int unsigned FIELD_W = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 2;

  // operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_INIT   = 1'b1;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_REPEAT     = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd30;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd800;
  localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd150;

  // timing settings shared by all lanes
  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
    logic [CFG_W-1:0] repeat_interval;
  } kdlpr_cfg_t;

  // per-item control broadcast to the lanes
  typedef struct packed {
    logic              accept;
    logic              init;
    logic [TIME_W-1:0] now;
  } kdlpr_ctrl_t;

  // events found by one lane
  typedef struct packed {
    logic press;
    logic release_ev;
    logic short_ev;
    logic long_ev;
    logic repeat_ev;
  } kdlpr_ev_t;

  // one result item
  typedef struct packed {
    logic [FIELD_W-1:0] pressed_events;
    logic [FIELD_W-1:0] released_events;
    logic [FIELD_W-1:0] short_press_events;
    logic [FIELD_W-1:0] long_press_events;
    logic [FIELD_W-1:0] repeat_events;
  } kdlpr_res_t;

endpackage

[src/kdlpr_if.sv]
// input sample channel
interface kdlpr_item_if
  import kdlpr_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [FIELD_W-1:0] raw_keys;
  logic [TIME_W-1:0]  time_ms;

  modport source (output valid, operation, raw_keys, time_ms, input ready);
  modport sink   (input valid, operation, raw_keys, time_ms, output ready);
endinterface

// event result channel
interface kdlpr_result_if
  import kdlpr_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] pressed_events;
  logic [FIELD_W-1:0] released_events;
  logic [FIELD_W-1:0] short_press_events;
  logic [FIELD_W-1:0] long_press_events;
  logic [FIELD_W-1:0] repeat_events;

  modport source (output valid, pressed_events, released_events, short_press_events,
                  long_press_events, repeat_events, input ready);
  modport sink   (input valid, pressed_events, released_events, short_press_events,
                  long_press_events, repeat_events, output ready);
endinterface

// configuration write channel
interface kdlpr_cfg_if
  import kdlpr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CFG_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/kdlpr_lane.sv]
module kdlpr_lane
  import kdlpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        raw_i,
  input  kdlpr_ctrl_t ctrl_i,
  input  kdlpr_cfg_t  cfg_i,
  output kdlpr_ev_t   ev_o
);

  logic              raw_q, raw_d;
  logic              stable_q, stable_d;
  logic              long_q, long_d;
  logic [TIME_W-1:0] chg_time_q, chg_time_d;
  logic [TIME_W-1:0] press_time_q, press_time_d;
  logic [TIME_W-1:0] rep_time_q, rep_time_d;

  logic              raw_chg;
  logic              stab_chg;
  logic              press_now;
  logic              long_mid;
  logic [TIME_W-1:0] db_age, press_age, rep_age;
  logic              db_ok, long_ok, rep_ok;
  kdlpr_ev_t         ev;

  // elapsed times from the stored stamps, all in parallel
  always_comb begin
    raw_chg   = raw_i != raw_q;
    db_age    = raw_chg ? '0 : ctrl_i.now - chg_time_q;
    db_ok     = db_age >= {{(TIME_W-CFG_W){1'b0}}, cfg_i.debounce_time};
    stab_chg  = (stable_q != raw_i) && db_ok;
    press_now = stab_chg && raw_i;
    press_age = press_now ? '0 : ctrl_i.now - press_time_q;
    long_ok   = press_age >= {{(TIME_W-CFG_W){1'b0}}, cfg_i.long_press_time};
    rep_age   = ctrl_i.now - rep_time_q;
    rep_ok    = rep_age >= {{(TIME_W-CFG_W){1'b0}}, cfg_i.repeat_interval};
    long_mid  = stab_chg ? 1'b0 : long_q;
  end

  // next state and events for an update, init overrides
  always_comb begin
    raw_d        = raw_i;
    chg_time_d   = raw_chg ? ctrl_i.now : chg_time_q;
    stable_d     = stab_chg ? raw_i : stable_q;
    long_d       = long_mid;
    press_time_d = press_now ? ctrl_i.now : press_time_q;
    rep_time_d   = press_now ? ctrl_i.now : rep_time_q;
    ev           = '0;
    ev.press      = press_now;
    ev.release_ev = stab_chg && !raw_i;
    ev.short_ev   = stab_chg && !raw_i && !long_q;
    if (stable_d) begin
      if (!long_mid) begin
        if (long_ok) begin
          long_d     = 1'b1;
          rep_time_d = ctrl_i.now;
          ev.long_ev = 1'b1;
        end
      end else if (rep_ok) begin
        rep_time_d   = ctrl_i.now;
        ev.repeat_ev = 1'b1;
      end
    end
    if (ctrl_i.init) begin
      raw_d        = raw_i;
      stable_d     = raw_i;
      long_d       = 1'b0;
      chg_time_d   = ctrl_i.now;
      press_time_d = ctrl_i.now;
      rep_time_d   = ctrl_i.now;
      ev           = '0;
    end
  end

  assign ev_o = ev;

  // key state, updated on each accepted transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q        <= 1'b0;
      stable_q     <= 1'b0;
      long_q       <= 1'b0;
      chg_time_q   <= '0;
      press_time_q <= '0;
      rep_time_q   <= '0;
    end else if (ctrl_i.accept) begin
      raw_q        <= raw_d;
      stable_q     <= stable_d;
      long_q       <= long_d;
      chg_time_q   <= chg_time_d;
      press_time_q <= press_time_d;
      rep_time_q   <= rep_time_d;
    end
  end

`ifndef SYNTHESIS
  // long press only ever recorded on a pressed key
  a_long_needs_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_q |-> stable_q)
    else $error("long press flag set on a released key");

  // press and release never in one transfer
  a_press_release_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ev_o.press && ev_o.release_ev))
    else $error("press and release in one transfer");

  // short press comes only with a release
  a_short_is_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_o.short_ev |-> ev_o.release_ev)
    else $error("short press without release");

  // init leaves the key settled with no long press pending
  a_init_settles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.accept && ctrl_i.init) |=> (stable_q == raw_q) && !long_q)
    else $error("init did not settle key state");
`endif

endmodule

[src/kdlpr_merge.sv]
module kdlpr_merge
  import kdlpr_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  kdlpr_ev_t [KEY_COUNT-1:0] ev_i,
  kdlpr_result_if.source            result_o
);

  localparam int unsigned OUT_KEYS = (KEY_COUNT < FIELD_W) ? KEY_COUNT : FIELD_W;

  logic [FIELD_W-1:0] press_w, release_w, short_w, long_w, rep_w;
  kdlpr_res_t         res_q;
  logic               valid_q, valid_d;
  logic               accept;

  // gather lane events into the result fields
  for (genvar g = 0; g < FIELD_W; g++) begin : g_bit
    if (g < OUT_KEYS) begin : g_lane
      assign press_w[g]   = ev_i[g].press;
      assign release_w[g] = ev_i[g].release_ev;
      assign short_w[g]   = ev_i[g].short_ev;
      assign long_w[g]    = ev_i[g].long_ev;
      assign rep_w[g]     = ev_i[g].repeat_ev;
    end else begin : g_none
      assign press_w[g]   = 1'b0;
      assign release_w[g] = 1'b0;
      assign short_w[g]   = 1'b0;
      assign long_w[g]    = 1'b0;
      assign rep_w[g]     = 1'b0;
    end
  end

  // output register, refilled in the cycle it drains
  assign in_ready_o = !valid_q || result_o.ready;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q.pressed_events     <= press_w;
      res_q.released_events    <= release_w;
      res_q.short_press_events <= short_w;
      res_q.long_press_events  <= long_w;
      res_q.repeat_events      <= rep_w;
    end
  end

  assign result_o.valid              = valid_q;
  assign result_o.pressed_events     = res_q.pressed_events;
  assign result_o.released_events    = res_q.released_events;
  assign result_o.short_press_events = res_q.short_press_events;
  assign result_o.long_press_events  = res_q.long_press_events;
  assign result_o.repeat_events      = res_q.repeat_events;

`ifndef SYNTHESIS
  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !result_o.ready) |-> !accept)
    else $error("result overwritten while stalled");

  // every accepted transfer shows up as a valid result
  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_q)
    else $error("accepted transfer lost");

  // result drops only after it was taken
  a_drop_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(valid_q) |-> $past(result_o.ready))
    else $error("result dropped without transfer");
`endif

endmodule

[src/key_debounce_long_press_repeat.sv]
// channel   modport  payload                                         handshake
// item_i    sink     operation, raw_keys[7:0], time_ms[31:0]         valid/ready
// result_o  source   pressed/released/short_press/long_press/repeat  valid/ready
// cfg_i     sink     index[1:0], data[15:0]                          valid/ready
//
// one sample per cycle while no result is stalled; each key has its own lane with three 32-bit
// subtract-compares in parallel, results are registered and show in the cycle after the transfer
// reset clears all key state and loads the default timings; no clearing pass
// a stalled result holds in the output register, item_i.ready follows
// result_o.ready while a result waits; configuration writes always complete
module key_debounce_long_press_repeat
  import kdlpr_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  kdlpr_item_if.sink     item_i,
  kdlpr_result_if.source result_o,
  kdlpr_cfg_if.sink      cfg_i
);

  kdlpr_cfg_t                cfg_q, cfg_d;
  kdlpr_ctrl_t               ctrl;
  logic                      item_ready;
  logic [KEY_COUNT-1:0]      raw_w;
  kdlpr_ev_t [KEY_COUNT-1:0] ev_w;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_DEBOUNCE:   cfg_d.debounce_time   = cfg_i.data;
        CFG_LONG_PRESS: cfg_d.long_press_time = cfg_i.data;
        CFG_REPEAT:     cfg_d.repeat_interval = cfg_i.data;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time   <= DEBOUNCE_RST;
      cfg_q.long_press_time <= LONG_PRESS_RST;
      cfg_q.repeat_interval <= REPEAT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // per-transfer control to all lanes
  assign item_i.ready = item_ready;
  assign ctrl.accept  = item_i.valid && item_ready;
  assign ctrl.init    = item_i.operation == OP_INIT;
  assign ctrl.now     = item_i.time_ms;

  // one lane per key; keys past the sample width see a released level
  for (genvar g = 0; g < KEY_COUNT; g++) begin : g_key
    if (g < FIELD_W) begin : g_in
      assign raw_w[g] = item_i.raw_keys[g];
    end else begin : g_off
      assign raw_w[g] = 1'b0;
    end

    kdlpr_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .raw_i  (raw_w[g]),
      .ctrl_i (ctrl),
      .cfg_i  (cfg_q),
      .ev_o   (ev_w[g])
    );
  end

  // merge lane events into the result register
  kdlpr_merge #(
    .KEY_COUNT (KEY_COUNT)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_ready),
    .ev_i       (ev_w),
    .result_o   (result_o)
  );

endmodule
